// ===== hw/rtl/bfa_pkg.sv =====
// bfa_pkg: shared types and constants of the buddy frame allocator
// no dependencies; used by the channel interfaces and buddy_frame_allocator
package bfa_pkg;

  localparam int unsigned ORDER_W  = 4;
  localparam int unsigned FRAME_W  = 12;
  localparam int unsigned FREE_W   = 13;
  localparam int unsigned STATUS_W = 2;

  // order map code for a frame that heads no free block
  localparam logic [ORDER_W-1:0] ORD_VACANT = 4'hF;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_NO_MEM = 2'd1,
    STS_BAD_ORDER = 2'd2
  } status_e;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

endpackage

// ===== hw/rtl/bfa_req_if.sv =====
// bfa_req_if: request channel of the buddy frame allocator
// depends on bfa_pkg
interface bfa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [bfa_pkg::ORDER_W-1:0]  order;
  logic [bfa_pkg::FRAME_W-1:0]  frame_index;

  modport source (output valid, mode, order, frame_index, input ready);
  modport sink   (input valid, mode, order, frame_index, output ready);
endinterface

// ===== hw/rtl/bfa_rsp_if.sv =====
// bfa_rsp_if: response channel of the buddy frame allocator
// depends on bfa_pkg
interface bfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bfa_pkg::STATUS_W-1:0]  status;
  logic [bfa_pkg::FRAME_W-1:0]   block_frame;
  logic [bfa_pkg::FREE_W-1:0]    avail_frames;

  modport source (output valid, status, block_frame, avail_frames, input ready);
  modport sink   (input valid, status, block_frame, avail_frames, output ready);
endinterface

// ===== hw/rtl/buddy_frame_allocator.sv =====
// buddy_frame_allocator: binary buddy allocator over page frames
// depends on bfa_pkg, bfa_req_if, bfa_rsp_if
//
// Usage: req_i carries one transaction per request: mode (0 allocate,
// 1 free), order (log2 of the block size) and frame_index (free only).
// rsp_o returns one transaction per request: status, block_frame of an
// allocation and the free frame count after the request.
// The block works on one request at a time under a small sequencer that
// shares one order-map port and one port per link memory. A bad order or
// a free outside memory goes straight to the response load; an allocation
// scans the orders upward, unlinks the block that it finds and splits it
// down, pushing each upper half; a free checks its buddy, unlinks it and
// merges per step and ends with a push. Link and order-map reads are
// registered, so the unlink reads in ST_UNL_RD before it writes in
// ST_UNL_WR, and the merge check reads in ST_MCHK before ST_MCMP compares.
// After reset a clearing pass writes "none" into every order-map entry
// while req_i is not ready. Free lists start empty and the free count at
// zero; memory is seeded by freeing single frames. A result sits in an
// output register, so a stalled receiver holds only the next request's
// completion, not its acceptance.
module buddy_frame_allocator #(
  parameter int unsigned NUM_FRAMES = 4096,
  parameter int unsigned MAX_ORDER  = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  bfa_req_if.sink        req_i,
  bfa_rsp_if.source      rsp_o
);

  localparam int unsigned IDX_W  = (NUM_FRAMES > 2) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned LINK_W = $clog2(NUM_FRAMES + 1);
  localparam int unsigned KIDX_W = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
  localparam int unsigned SW0    = (LINK_W > bfa_pkg::FRAME_W) ? LINK_W : bfa_pkg::FRAME_W;
  localparam int unsigned SW1    = (SW0 > MAX_ORDER + 1) ? SW0 : MAX_ORDER + 1;
  localparam int unsigned SUM_W  = SW1 + 1;
  localparam int unsigned NHEADS = MAX_ORDER + 1;

  localparam logic [LINK_W-1:0]            NULL_LINK = LINK_W'(NUM_FRAMES);
  localparam logic [SUM_W-1:0]             NUM_W     = SUM_W'(NUM_FRAMES);
  localparam logic [bfa_pkg::ORDER_W-1:0]  MAX_ORD   = bfa_pkg::ORDER_W'(MAX_ORDER);

  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] ST_CLEAR  = 4'd0;
  localparam logic [ST_W-1:0] ST_IDLE   = 4'd1;
  localparam logic [ST_W-1:0] ST_SCAN   = 4'd2;
  localparam logic [ST_W-1:0] ST_UNL_RD = 4'd3;
  localparam logic [ST_W-1:0] ST_UNL_WR = 4'd4;
  localparam logic [ST_W-1:0] ST_SPLIT  = 4'd5;
  localparam logic [ST_W-1:0] ST_PUSH1  = 4'd6;
  localparam logic [ST_W-1:0] ST_PUSH2  = 4'd7;
  localparam logic [ST_W-1:0] ST_MCHK   = 4'd8;
  localparam logic [ST_W-1:0] ST_MCMP   = 4'd9;
  localparam logic [ST_W-1:0] ST_FIN    = 4'd10;

  logic [ST_W-1:0]               state_q, state_d;
  logic                          mode_q, mode_d;
  logic [bfa_pkg::ORDER_W-1:0]   ord_q, ord_d;
  logic [bfa_pkg::ORDER_W-1:0]   k_q, k_d;
  logic [IDX_W-1:0]              f_q, f_d;
  logic [IDX_W-1:0]              u_q, u_d;
  logic [IDX_W-1:0]              pblk_q, pblk_d;
  logic [bfa_pkg::ORDER_W-1:0]   pord_q, pord_d;
  logic [LINK_W-1:0]             h_q, h_d;
  logic [LINK_W-1:0]             fc_q, fc_d;
  logic [IDX_W-1:0]              clr_q, clr_d;
  logic [LINK_W-1:0]             heads_q [NHEADS];
  bfa_pkg::status_e              sts_q, sts_d;
  logic [IDX_W-1:0]              res_q, res_d;

  logic                          rsp_valid_q, rsp_valid_d;
  bfa_pkg::status_e              rsp_sts_q, rsp_sts_d;
  logic [bfa_pkg::FRAME_W-1:0]   rsp_frame_q, rsp_frame_d;
  logic [bfa_pkg::FREE_W-1:0]    rsp_free_q, rsp_free_d;

  // memories
  logic [bfa_pkg::ORDER_W-1:0]   omap_mem  [NUM_FRAMES];
  logic [LINK_W-1:0]             nlink_mem [NUM_FRAMES];
  logic [LINK_W-1:0]             plink_mem [NUM_FRAMES];

  logic                          om_we, nl_we, pl_we;
  logic [IDX_W-1:0]              om_waddr, nl_waddr, pl_waddr, om_raddr;
  logic [bfa_pkg::ORDER_W-1:0]   om_wdata, om_rd_q;
  logic [LINK_W-1:0]             nl_wdata, pl_wdata, nl_rd_q, pl_rd_q;

  logic                          head_we;
  logic [KIDX_W-1:0]             head_widx;
  logic [LINK_W-1:0]             head_wdata;

  // shared datapath
  logic [SUM_W-1:0] req_size, cur_size, bit_k, bit_km1, buddy_w, split_w, fc_sum, req_end;
  logic [LINK_W-1:0] head_k, head_p;
  logic req_fire;

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  assign req_size = SUM_W'(1) << req_i.order;
  assign cur_size = SUM_W'(1) << ord_q;
  assign bit_k    = SUM_W'(1) << k_q;
  assign bit_km1  = SUM_W'(1) << (k_q - 4'd1);
  assign buddy_w  = SUM_W'(f_q) ^ bit_k;
  assign split_w  = SUM_W'(f_q) + bit_km1;
  assign req_end  = SUM_W'(req_i.frame_index) + req_size;
  assign fc_sum   = SUM_W'(fc_q) + req_size;
  assign head_k   = heads_q[k_q[KIDX_W-1:0]];
  assign head_p   = heads_q[pord_q[KIDX_W-1:0]];
  assign om_raddr = buddy_w[IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    ord_d       = ord_q;
    k_d         = k_q;
    f_d         = f_q;
    u_d         = u_q;
    pblk_d      = pblk_q;
    pord_d      = pord_q;
    h_d         = h_q;
    fc_d        = fc_q;
    clr_d       = clr_q;
    sts_d       = sts_q;
    res_d       = res_q;
    om_we       = 1'b0;
    om_waddr    = u_q;
    om_wdata    = bfa_pkg::ORD_VACANT;
    nl_we       = 1'b0;
    nl_waddr    = pl_rd_q[IDX_W-1:0];
    nl_wdata    = nl_rd_q;
    pl_we       = 1'b0;
    pl_waddr    = nl_rd_q[IDX_W-1:0];
    pl_wdata    = pl_rd_q;
    head_we     = 1'b0;
    head_widx   = k_q[KIDX_W-1:0];
    head_wdata  = nl_rd_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_sts_d   = rsp_sts_q;
    rsp_frame_d = rsp_frame_q;
    rsp_free_d  = rsp_free_q;

    unique case (state_q)
      ST_CLEAR: begin
        om_we    = 1'b1;
        om_waddr = clr_q;
        clr_d    = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(NUM_FRAMES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          mode_d = req_i.mode;
          ord_d  = req_i.order;
          k_d    = req_i.order;
          f_d    = IDX_W'(req_i.frame_index);
          sts_d  = bfa_pkg::STS_OK;
          res_d  = '0;
          if (req_i.order > MAX_ORD) begin
            sts_d   = bfa_pkg::STS_BAD_ORDER;
            state_d = ST_FIN;
          end else if (req_i.mode == bfa_pkg::MODE_ALLOC) begin
            state_d = ST_SCAN;
          end else if (req_end <= NUM_W) begin
            fc_d    = (fc_sum > NUM_W) ? NULL_LINK : LINK_W'(fc_sum);
            state_d = ST_MCHK;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (k_q > MAX_ORD) begin
          sts_d   = bfa_pkg::STS_NO_MEM;
          state_d = ST_FIN;
        end else if (head_k < NULL_LINK) begin
          f_d     = head_k[IDX_W-1:0];
          u_d     = head_k[IDX_W-1:0];
          state_d = ST_UNL_RD;
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      ST_UNL_RD: begin
        state_d = ST_UNL_WR;
      end
      ST_UNL_WR: begin
        // pl_rd_q is the predecessor, nl_rd_q the successor of the removed block
        om_we = 1'b1;
        if (pl_rd_q < NULL_LINK) begin
          nl_we = 1'b1;
        end else begin
          head_we = 1'b1;
        end
        pl_we = (nl_rd_q < NULL_LINK);
        if (mode_q == bfa_pkg::MODE_ALLOC) begin
          res_d   = f_q;
          state_d = ST_SPLIT;
        end else begin
          f_d     = f_q & ~bit_k[IDX_W-1:0];
          k_d     = k_q + 4'd1;
          state_d = ST_MCHK;
        end
      end
      ST_SPLIT: begin
        if (k_q > ord_q) begin
          k_d = k_q - 4'd1;
          if (split_w < NUM_W) begin
            pblk_d  = split_w[IDX_W-1:0];
            pord_d  = k_q - 4'd1;
            state_d = ST_PUSH1;
          end
        end else begin
          fc_d    = (SUM_W'(fc_q) > cur_size) ? LINK_W'(SUM_W'(fc_q) - cur_size) : '0;
          state_d = ST_FIN;
        end
      end
      ST_PUSH1: begin
        pl_we      = 1'b1;
        pl_waddr   = pblk_q;
        pl_wdata   = NULL_LINK;
        nl_we      = 1'b1;
        nl_waddr   = pblk_q;
        nl_wdata   = head_p;
        om_we      = 1'b1;
        om_waddr   = pblk_q;
        om_wdata   = pord_q;
        head_we    = 1'b1;
        head_widx  = pord_q[KIDX_W-1:0];
        head_wdata = LINK_W'(pblk_q);
        h_d        = head_p;
        if (head_p < NULL_LINK) begin
          state_d = ST_PUSH2;
        end else begin
          state_d = (mode_q == bfa_pkg::MODE_ALLOC) ? ST_SPLIT : ST_FIN;
        end
      end
      ST_PUSH2: begin
        pl_we    = 1'b1;
        pl_waddr = h_q[IDX_W-1:0];
        pl_wdata = LINK_W'(pblk_q);
        state_d  = (mode_q == bfa_pkg::MODE_ALLOC) ? ST_SPLIT : ST_FIN;
      end
      ST_MCHK: begin
        // buddy order is read from om_raddr while the range is checked
        if (k_q < MAX_ORD && buddy_w < NUM_W) begin
          u_d     = buddy_w[IDX_W-1:0];
          state_d = ST_MCMP;
        end else begin
          pblk_d  = f_q;
          pord_d  = k_q;
          state_d = ST_PUSH1;
        end
      end
      ST_MCMP: begin
        if (om_rd_q == k_q) begin
          state_d = ST_UNL_RD;
        end else begin
          pblk_d  = f_q;
          pord_d  = k_q;
          state_d = ST_PUSH1;
        end
      end
      ST_FIN: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_sts_d   = sts_q;
          rsp_frame_d = (sts_q == bfa_pkg::STS_OK && mode_q == bfa_pkg::MODE_ALLOC)
                        ? bfa_pkg::FRAME_W'(res_q) : '0;
          rsp_free_d  = bfa_pkg::FREE_W'(fc_d);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      fc_q        <= '0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < NHEADS; i++) begin
        heads_q[i] <= NULL_LINK;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fc_q        <= fc_d;
      rsp_valid_q <= rsp_valid_d;
      if (head_we) begin
        heads_q[head_widx] <= head_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    ord_q       <= ord_d;
    k_q         <= k_d;
    f_q         <= f_d;
    u_q         <= u_d;
    pblk_q      <= pblk_d;
    pord_q      <= pord_d;
    h_q         <= h_d;
    sts_q       <= sts_d;
    res_q       <= res_d;
    rsp_sts_q   <= rsp_sts_d;
    rsp_frame_q <= rsp_frame_d;
    rsp_free_q  <= rsp_free_d;
  end

  always_ff @(posedge clk_i) begin
    if (om_we) begin
      omap_mem[om_waddr] <= om_wdata;
    end
    om_rd_q <= omap_mem[om_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (nl_we) begin
      nlink_mem[nl_waddr] <= nl_wdata;
    end
    nl_rd_q <= nlink_mem[u_q];
  end

  always_ff @(posedge clk_i) begin
    if (pl_we) begin
      plink_mem[pl_waddr] <= pl_wdata;
    end
    pl_rd_q <= plink_mem[u_q];
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_sts_q;
  assign rsp_o.block_frame  = rsp_frame_q;
  assign rsp_o.avail_frames = rsp_free_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= NULL_LINK)
    else $error("free count above frame count");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q != ST_IDLE)
    else $error("request accepted without starting work");

  a_push_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PUSH1 |-> (SUM_W'(pblk_q) < NUM_W && pord_q <= MAX_ORD))
    else $error("push outside memory or order range");

  a_fin_loads_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && (!rsp_valid_q || rsp_o.ready)) |=> rsp_valid_q)
    else $error("finished request produced no response");

endmodule
